// ===== hw/rtl/qnn_pkg.sv =====
// Shared types and constants for the quadrant nearest-neighbour select block.
// Used by the channel interfaces, the front stage, the slot table and the top level.
package qnn_pkg;

	localparam int NumQuads    = 4;
	localparam int MaxEdgesDef = 2;
	localparam int CoordW      = 16;
	localparam int IdW         = 16;
	localparam int SqW         = 32;
	localparam int DistW       = 33;
	localparam int StatusW     = 3;
	localparam int QuadW       = 2;
	localparam int CountW      = 2;
	localparam int CfgIdxW     = 2;
	localparam int CfgDataW    = 16;

	// result status codes
	typedef enum logic [StatusW-1:0] {
		ST_ADDED      = 3'd0,
		ST_REPLACED   = 3'd1,
		ST_NOT_NEARER = 3'd2,
		ST_AXIS       = 3'd3,
		ST_SELF       = 3'd4
	} status_t;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_ORIGIN_X = 2'd0,
		REG_ORIGIN_Y = 2'd1,
		REG_SELF_ID  = 2'd2
	} cfg_reg_t;

	// candidate after the front stage: squares, quadrant and skip flags
	typedef struct packed {
		logic             is_self;
		logic             on_axis;
		logic [QuadW-1:0] quad;
		logic [IdW-1:0]   id;
		logic [SqW-1:0]   sq_x;
		logic [SqW-1:0]   sq_y;
	} cand_t;

	// one result word
	typedef struct packed {
		status_t           status;
		logic [QuadW-1:0]  quadrant;
		logic [CountW-1:0] entry_count;
		logic [IdW-1:0]    near_id;
		logic [DistW-1:0]  near_dist_sq;
		logic [IdW-1:0]    far_id;
		logic [DistW-1:0]  far_dist_sq;
	} result_t;

endpackage

// ===== hw/rtl/qnn_node_if.sv =====
// Candidate node channel: valid/ready handshake with pixel position and id.
// Depends on qnn_pkg for field widths.
interface qnn_node_if import qnn_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CoordW-1:0] node_x;
	logic [CoordW-1:0] node_y;
	logic [IdW-1:0]    node_id;

	modport source (output valid, output node_x, output node_y, output node_id, input ready);
	modport sink (input valid, input node_x, input node_y, input node_id, output ready);
endinterface

// ===== hw/rtl/qnn_result_if.sv =====
// Result channel: valid/ready handshake with status and quadrant contents.
// Depends on qnn_pkg for field widths.
interface qnn_result_if import qnn_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [StatusW-1:0] status;
	logic [QuadW-1:0]   quadrant;
	logic [CountW-1:0]  entry_count;
	logic [IdW-1:0]     near_id;
	logic [DistW-1:0]   near_dist_sq;
	logic [IdW-1:0]     far_id;
	logic [DistW-1:0]   far_dist_sq;

	modport source (output valid, output status, output quadrant, output entry_count,
		output near_id, output near_dist_sq, output far_id, output far_dist_sq, input ready);
	modport sink (input valid, input status, input quadrant, input entry_count,
		input near_id, input near_dist_sq, input far_id, input far_dist_sq, output ready);
endinterface

// ===== hw/rtl/qnn_front.sv =====
// Front stage: deltas to the origin, quadrant, skip flags and the two squares.
// Depends on qnn_pkg; the result is registered into the second pipeline stage.
module qnn_front import qnn_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [CoordW-1:0] node_x,
	input  logic [CoordW-1:0] node_y,
	input  logic [IdW-1:0]    node_id,
	input  logic [CoordW-1:0] origin_x,
	input  logic [CoordW-1:0] origin_y,
	input  logic [IdW-1:0]    self_id,
	output cand_t             cand_s2
);

	logic              x_neg;
	logic              y_neg;
	logic [CoordW-1:0] abs_x;
	logic [CoordW-1:0] abs_y;
	cand_t             cand;

	// absolute deltas; sign of origin minus node picks the quadrant
	always_comb begin
		x_neg        = origin_x < node_x;
		y_neg        = origin_y < node_y;
		abs_x        = x_neg ? node_x - origin_x : origin_x - node_x;
		abs_y        = y_neg ? node_y - origin_y : origin_y - node_y;
		cand.is_self = node_id == self_id;
		cand.on_axis = (node_x == origin_x) || (node_y == origin_y);
		cand.quad    = {x_neg, y_neg};
		cand.id      = node_id;
		cand.sq_x    = SqW'(abs_x) * SqW'(abs_x);
		cand.sq_y    = SqW'(abs_y) * SqW'(abs_y);
	end

	// stage 2 register
	always_ff @(posedge clk) begin
		if (en) begin
			cand_s2 <= cand;
		end
	end

endmodule

// ===== hw/rtl/qnn_table.sv =====
// Per-quadrant sorted slot table: insert, evict-farthest and id overwrite.
// Depends on qnn_pkg; updates at most one quadrant row per fired word and forms the result.
module qnn_table import qnn_pkg::*; #(
	parameter int MAX_EDGES = MaxEdgesDef
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  cand_t   cand,
	output result_t res
);

	localparam int CntW   = $clog2(MAX_EDGES + 1);
	localparam int FarIdx = (MAX_EDGES > 1) ? 1 : 0;

	// slot storage; valid bits form a sorted prefix in each row
	logic [NumQuads-1:0][MAX_EDGES-1:0] slot_v_q;
	logic [DistW-1:0]                   slot_d_q  [NumQuads][MAX_EDGES];
	logic [IdW-1:0]                     slot_id_q [NumQuads][MAX_EDGES];

	logic [DistW-1:0]     cand_d;
	logic [MAX_EDGES-1:0] row_v;
	logic [MAX_EDGES-1:0] new_v;
	logic [DistW-1:0]     row_d   [MAX_EDGES];
	logic [DistW-1:0]     new_d   [MAX_EDGES];
	logic [IdW-1:0]       row_id  [MAX_EDGES];
	logic [IdW-1:0]       new_id  [MAX_EDGES];
	logic [MAX_EDGES-1:0] in_lim;
	logic [MAX_EDGES-1:0] lt;
	logic [MAX_EDGES-1:0] eq;
	logic [CntW-1:0]      cnt_old;
	logic [CntW-1:0]      cnt_new;
	logic [CntW-1:0]      lim;
	logic                 full;
	logic                 evict;
	logic                 act;
	logic                 any_eq;
	logic                 prev_lt;
	logic [DistW-1:0]     prev_d;
	logic [IdW-1:0]       prev_id;

	// row read, compare against the held entries and build the new row
	always_comb begin
		cand_d = DistW'(cand.sq_x) + DistW'(cand.sq_y);
		row_v  = slot_v_q[cand.quad];
		for (int i = 0; i < MAX_EDGES; i++) begin
			row_d[i]  = slot_d_q[cand.quad][i];
			row_id[i] = slot_id_q[cand.quad][i];
		end
		cnt_old = '0;
		for (int i = 0; i < MAX_EDGES; i++) begin
			cnt_old = cnt_old + CntW'(row_v[i]);
		end
		full  = row_v[MAX_EDGES-1];
		evict = full && (row_d[MAX_EDGES-1] > cand_d);
		act   = !cand.is_self && !cand.on_axis && (!full || evict);
		// on eviction the farthest slot drops out and the rest is searched
		lim   = full ? CntW'(MAX_EDGES - 1) : cnt_old;
		for (int i = 0; i < MAX_EDGES; i++) begin
			in_lim[i] = CntW'(i) < lim;
			lt[i]     = in_lim[i] && (row_d[i] < cand_d);
			eq[i]     = in_lim[i] && (row_d[i] == cand_d);
		end
		any_eq = |eq;

		new_v   = row_v;
		prev_lt = 1'b1;
		prev_d  = '0;
		prev_id = '0;
		for (int i = 0; i < MAX_EDGES; i++) begin
			new_d[i]  = row_d[i];
			new_id[i] = row_id[i];
			if (act) begin
				if (any_eq) begin
					if (eq[i]) begin
						new_id[i] = cand.id;
					end
				end else begin
					// at the insert point take the candidate, above it shift up
					if ((CntW'(i) <= lim) && !lt[i]) begin
						if (prev_lt) begin
							new_d[i]  = cand_d;
							new_id[i] = cand.id;
						end else begin
							new_d[i]  = prev_d;
							new_id[i] = prev_id;
						end
					end
					if (CntW'(i) == lim) begin
						new_v[i] = 1'b1;
					end
				end
			end
			prev_lt = lt[i];
			prev_d  = row_d[i];
			prev_id = row_id[i];
		end
		// equal key after eviction: farthest is gone, count drops by one
		if (act && any_eq && evict) begin
			new_v[MAX_EDGES-1] = 1'b0;
		end

		cnt_new = '0;
		for (int i = 0; i < MAX_EDGES; i++) begin
			cnt_new = cnt_new + CntW'(new_v[i]);
		end
	end

	// result word
	always_comb begin
		res = '0;
		if (cand.is_self) begin
			res.status = ST_SELF;
		end else if (cand.on_axis) begin
			res.status = ST_AXIS;
		end else begin
			if (!full) begin
				res.status = ST_ADDED;
			end else if (evict) begin
				res.status = ST_REPLACED;
			end else begin
				res.status = ST_NOT_NEARER;
			end
			res.quadrant    = cand.quad;
			res.entry_count = CountW'(cnt_new);
			if (cnt_new >= 1) begin
				res.near_id      = new_id[0];
				res.near_dist_sq = new_d[0];
			end
			if (cnt_new >= 2) begin
				res.far_id      = new_id[FarIdx];
				res.far_dist_sq = new_d[FarIdx];
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_v_q <= '0;
		end else if (fire && act) begin
			slot_v_q[cand.quad] <= new_v;
		end
	end

	// slot payload
	always_ff @(posedge clk) begin
		if (fire && act) begin
			for (int i = 0; i < MAX_EDGES; i++) begin
				slot_d_q[cand.quad][i]  <= new_d[i];
				slot_id_q[cand.quad][i] <= new_id[i];
			end
		end
	end

`ifndef ASSERT_OFF
	// rows stay a valid prefix, sorted strictly ascending
	for (genvar qi = 0; qi < NumQuads; qi++) begin : g_row_chk
		for (genvar si = 1; si < MAX_EDGES; si++) begin : g_slot_chk
			a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
				slot_v_q[qi][si] |-> slot_v_q[qi][si-1])
				else $error("slot valid bits not a prefix");
			a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
				slot_v_q[qi][si] |-> (slot_d_q[qi][si-1] < slot_d_q[qi][si]))
				else $error("slot keys not strictly ascending");
		end
	end

	// skipped or not-nearer words leave the table alone
	a_no_act_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !act) |=> $stable(slot_v_q))
		else $error("table changed on a word that takes no action");

	// a plain insert grows the row by one entry
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && act && !full && !any_eq) |-> (cnt_new == cnt_old + 1'b1))
		else $error("insert did not add an entry");
`endif

endmodule

// ===== hw/rtl/quadrant_nearest_neighbour_select_core.sv =====
// Quadrant nearest-neighbour select, top level.
// Depends on qnn_pkg, qnn_node_if, qnn_result_if, qnn_front and qnn_table.
//
// Usage:
//   node    - candidate words (node_x, node_y, node_id), valid/ready.
//   result  - one result word per candidate: status, quadrant, entry count and
//             the nearest and second entries of that quadrant.
//   cfg_we / cfg_index / cfg_data - register writes (origin_x, origin_y,
//             self_id); write only while no candidate is in flight.
// Pipeline: an accepted candidate passes the input register, the square stage and
//   the table update into the output register, which shows its result word.
// Throughput: one word per cycle while result.ready is high. The table row is
//   read, compared and written in the update stage, so the next candidate sees
//   it in the following cycle. Reset clears the configuration registers to zero
//   and empties all four quadrants at once; the block takes words right after reset.
// Receiver stall: the output register holds its word; the stages behind it
//   keep filling until each is occupied, then node.ready drops.
module quadrant_nearest_neighbour_select_core import qnn_pkg::*; #(
	parameter int MAX_EDGES = MaxEdgesDef
) (
	input  logic                clk,
	input  logic                arst_n,
	qnn_node_if.sink            node,
	qnn_result_if.source        result,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	logic [CoordW-1:0] origin_x_q;
	logic [CoordW-1:0] origin_y_q;
	logic [IdW-1:0]    self_id_q;

	logic              s1_v_q;
	logic              s2_v_q;
	logic              out_v_q;
	logic [CoordW-1:0] node_x_s1;
	logic [CoordW-1:0] node_y_s1;
	logic [IdW-1:0]    node_id_s1;
	cand_t             cand_s2;
	result_t           res;
	result_t           res_q;

	logic out_load;
	logic s2_load;
	logic s1_load;
	logic s2_fire;
	logic in_fire;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			self_id_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ORIGIN_X: origin_x_q <= cfg_data;
				REG_ORIGIN_Y: origin_y_q <= cfg_data;
				REG_SELF_ID:  self_id_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline flow: a stage loads when empty or when its word moves on
	assign out_load   = !out_v_q || result.ready;
	assign s2_load    = !s2_v_q || out_load;
	assign s1_load    = !s1_v_q || s2_load;
	assign s2_fire    = s2_v_q && out_load;
	assign in_fire    = node.valid && s1_load;
	assign node.ready = s1_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_load) begin
				s1_v_q <= node.valid;
			end
			if (s2_load) begin
				s2_v_q <= s1_v_q;
			end
			if (out_load) begin
				out_v_q <= s2_v_q;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (in_fire) begin
			node_x_s1  <= node.node_x;
			node_y_s1  <= node.node_y;
			node_id_s1 <= node.node_id;
		end
	end

	qnn_front u_front (
		.clk      (clk),
		.en       (s1_v_q && s2_load),
		.node_x   (node_x_s1),
		.node_y   (node_y_s1),
		.node_id  (node_id_s1),
		.origin_x (origin_x_q),
		.origin_y (origin_y_q),
		.self_id  (self_id_q),
		.cand_s2  (cand_s2)
	);

	qnn_table #(
		.MAX_EDGES (MAX_EDGES)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (s2_fire),
		.cand   (cand_s2),
		.res    (res)
	);

	// output register
	always_ff @(posedge clk) begin
		if (s2_fire) begin
			res_q <= res;
		end
	end

	assign result.valid        = out_v_q;
	assign result.status       = res_q.status;
	assign result.quadrant     = res_q.quadrant;
	assign result.entry_count  = res_q.entry_count;
	assign result.near_id      = res_q.near_id;
	assign result.near_dist_sq = res_q.near_dist_sq;
	assign result.far_id       = res_q.far_id;
	assign result.far_dist_sq  = res_q.far_dist_sq;

endmodule

// ===== tb/sv/tb_quadrant_nearest_neighbour_select_core.sv =====
`timescale 1ns / 1ps
// Testbench for quadrant_nearest_neighbour_select_core: directed and random candidate words,
// checked against an in-bench per-quadrant nearest-entry table. Depends on qnn_pkg and the
// qnn_node_if / qnn_result_if channel interfaces.
module tb_quadrant_nearest_neighbour_select_core;
	import qnn_pkg::*;

	localparam int Slots = MaxEdgesDef;
	// index outside the register map, writes to it must be dropped
	localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

	typedef struct {
		logic [CoordW-1:0] x;
		logic [CoordW-1:0] y;
		logic [IdW-1:0]    id;
		bit                drain_before;
	} node_word_t;

	logic clk;
	logic arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	qnn_node_if   node_ch ();
	qnn_result_if res_ch ();

	quadrant_nearest_neighbour_select_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.node      (node_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// expected copy of the registers and the quadrant tables
	logic [CoordW-1:0] org_x;
	logic [CoordW-1:0] org_y;
	logic [IdW-1:0]    own_id;
	logic [DistW-1:0]  quad_dist [NumQuads][Slots];
	logic [IdW-1:0]    quad_id   [NumQuads][Slots];
	logic              quad_used [NumQuads][Slots];

	node_word_t pending_nodes [$];
	result_t    expected_results [$];
	node_word_t next_word;
	result_t    want;

	int send_idle_pct;
	int recv_stall_pct;
	int errors;
	int words_sent;
	int results_checked;
	int settings_used;
	int status_seen [5];

	// entries held in a quadrant: valid slots form a prefix
	function automatic int held_in(int q);
		int n;
		n = 0;
		while (n < Slots && quad_used[q][n])
			n++;
		return n;
	endfunction

	// sorted insert into the first n slots, or overwrite the id of an equal distance
	function automatic void insert_sorted(int q, int n, logic [DistW-1:0] d, logic [IdW-1:0] id);
		int pos;
		int i;
		pos = n;
		for (i = 0; i < n; i++) begin
			if (quad_dist[q][i] == d) begin
				quad_id[q][i] = id;
				return;
			end
			if (quad_dist[q][i] > d) begin
				pos = i;
				break;
			end
		end
		for (i = n; i > pos; i--) begin
			quad_dist[q][i] = quad_dist[q][i-1];
			quad_id[q][i]   = quad_id[q][i-1];
		end
		quad_dist[q][pos] = d;
		quad_id[q][pos]   = id;
		quad_used[q][n]   = 1'b1;
	endfunction

	// table update for one candidate and the result word it should produce
	function automatic result_t predict_neighbour(logic [CoordW-1:0] nx, logic [CoordW-1:0] ny,
			logic [IdW-1:0] id);
		result_t r;
		logic [DistW-1:0] ax;
		logic [DistW-1:0] ay;
		logic [DistW-1:0] d;
		int q;
		int n;
		r = '0;
		if (id == own_id) begin
			r.status = ST_SELF;
			return r;
		end
		if (nx == org_x || ny == org_y) begin
			r.status = ST_AXIS;
			return r;
		end
		ax = (org_x > nx) ? org_x - nx : nx - org_x;
		ay = (org_y > ny) ? org_y - ny : ny - org_y;
		d  = ax * ax + ay * ay;
		q  = (org_x < nx ? 2 : 0) + (org_y < ny ? 1 : 0);
		n  = held_in(q);
		if (n < Slots) begin
			insert_sorted(q, n, d, id);
			r.status = ST_ADDED;
		end else if (quad_dist[q][n-1] > d) begin
			// drop the farthest, then insert as into a non-full quadrant
			quad_used[q][n-1] = 1'b0;
			quad_dist[q][n-1] = '0;
			quad_id[q][n-1]   = '0;
			insert_sorted(q, n - 1, d, id);
			r.status = ST_REPLACED;
		end else begin
			r.status = ST_NOT_NEARER;
		end
		n = held_in(q);
		r.quadrant    = q[QuadW-1:0];
		r.entry_count = n[CountW-1:0];
		if (n >= 1) begin
			r.near_id      = quad_id[q][0];
			r.near_dist_sq = quad_dist[q][0];
		end
		if (n >= 2) begin
			r.far_id      = quad_id[q][1];
			r.far_dist_sq = quad_dist[q][1];
		end
		return r;
	endfunction

	task automatic check_field(string name, longint unsigned exp_val, longint unsigned got_val);
		if (exp_val != got_val) begin
			errors++;
			$display("%0t: result %0d %s mismatch, expected %0d, got %0d", $time,
				results_checked, name, exp_val, got_val);
		end
	endtask

	task automatic queue_node(logic [CoordW-1:0] x, logic [CoordW-1:0] y, logic [IdW-1:0] id,
			bit drain_before);
		node_word_t w;
		w.x = x;
		w.y = y;
		w.id = id;
		w.drain_before = drain_before;
		pending_nodes.push_back(w);
	endtask

	// wait until every word is out and answered, then let the pipeline settle;
	// sampled mid-cycle so the driver's updates at the edge have landed
	task automatic wait_idle();
		while (pending_nodes.size() != 0 || node_ch.valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write all registers back to back, plus one write to an unmapped index
	task automatic write_config(logic [CoordW-1:0] x, logic [CoordW-1:0] y, logic [IdW-1:0] sid);
		wait_idle();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_ORIGIN_X;
		cfg_data  <= x;
		@(posedge clk);
		cfg_index <= REG_ORIGIN_Y;
		cfg_data  <= y;
		@(posedge clk);
		cfg_index <= REG_SELF_ID;
		cfg_data  <= sid;
		@(posedge clk);
		cfg_index <= RegUnused;
		cfg_data  <= CfgDataW'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		org_x  = x;
		org_y  = y;
		own_id = sid;
		settings_used++;
	endtask

	// coordinate a few pixels (sometimes further) off the origin, never on it
	function automatic logic [CoordW-1:0] near_coord(logic [CoordW-1:0] c);
		int off;
		int v;
		off = ($urandom_range(3) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 6);
		v = $urandom_range(1) ? int'(c) + off : int'(c) - off;
		if (v > 65535)
			v = int'(c) - off;
		if (v < 0)
			v = int'(c) + off;
		return v[CoordW-1:0];
	endfunction

	// mostly close candidates so quadrants keep churning; some self, axis and wide words
	task automatic add_random_nodes(int count);
		int i;
		int kind;
		logic [CoordW-1:0] x;
		logic [CoordW-1:0] y;
		logic [IdW-1:0] id;
		for (i = 0; i < count; i++) begin
			kind = $urandom_range(99);
			id   = IdW'($urandom);
			x    = near_coord(org_x);
			y    = near_coord(org_y);
			if (kind < 5) begin
				id = own_id;
				x  = CoordW'($urandom);
			end else if (kind < 8) begin
				x = org_x;
			end else if (kind < 11) begin
				y = org_y;
			end else if (kind < 26) begin
				x = CoordW'($urandom);
				y = CoordW'($urandom);
			end
			queue_node(x, y, id, i == count / 2);
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// candidate driver: holds the word until accepted, predicts at acceptance
	always @(posedge clk) begin
		if (!arst_n) begin
			node_ch.valid <= 1'b0;
		end else begin
			if (node_ch.valid && node_ch.ready) begin
				expected_results.push_back(predict_neighbour(node_ch.node_x, node_ch.node_y,
					node_ch.node_id));
				words_sent++;
			end
			if (!node_ch.valid || node_ch.ready) begin
				if (pending_nodes.size() != 0
						&& !(pending_nodes[0].drain_before && expected_results.size() != 0)
						&& $urandom_range(99) >= send_idle_pct) begin
					next_word = pending_nodes.pop_front();
					node_ch.valid   <= 1'b1;
					node_ch.node_x  <= next_word.x;
					node_ch.node_y  <= next_word.y;
					node_ch.node_id <= next_word.id;
				end else begin
					node_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compare each accepted word with the oldest expectation
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result word with none expected, status %0d", $time,
						res_ch.status);
				end else begin
					want = expected_results.pop_front();
					check_field("status", want.status, res_ch.status);
					check_field("quadrant", want.quadrant, res_ch.quadrant);
					check_field("entry_count", want.entry_count, res_ch.entry_count);
					check_field("near_id", want.near_id, res_ch.near_id);
					check_field("near_dist_sq", want.near_dist_sq, res_ch.near_dist_sq);
					check_field("far_id", want.far_id, res_ch.far_id);
					check_field("far_dist_sq", want.far_dist_sq, res_ch.far_dist_sq);
					status_seen[want.status]++;
					results_checked++;
				end
			end
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// stimulus and end of run
	initial begin
		int phase;
		node_ch.valid   = 1'b0;
		node_ch.node_x  = '0;
		node_ch.node_y  = '0;
		node_ch.node_id = '0;
		res_ch.ready    = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = REG_ORIGIN_X;
		cfg_data        = '0;
		arst_n          = 1'b0;
		errors          = 0;
		words_sent      = 0;
		results_checked = 0;
		settings_used   = 1;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		org_x           = '0;
		org_y           = '0;
		own_id          = '0;
		foreach (status_seen[i])
			status_seen[i] = 0;
		foreach (quad_used[q, s]) begin
			quad_used[q][s] = 1'b0;
			quad_dist[q][s] = '0;
			quad_id[q][s]   = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: origin at zero, own id zero
		queue_node(16'd100, 16'd200, 16'h0000, 1'b0);    // self
		queue_node(16'd0, 16'd50, 16'h0001, 1'b0);       // on the y axis
		queue_node(16'd50, 16'd0, 16'h0002, 1'b0);       // on the x axis
		queue_node(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);  // largest distance
		queue_node(16'd1, 16'd1, 16'h0003, 1'b0);        // fills the quadrant
		queue_node(16'd2, 16'd2, 16'h0004, 1'b0);        // evicts the farthest
		queue_node(16'd2, 16'd2, 16'h0005, 1'b0);        // equal to farthest, not nearer
		queue_node(16'd1, 16'd1, 16'h0006, 1'b0);        // equal key after eviction
		queue_node(16'd1, 16'd1, 16'h0007, 1'b0);        // equal key while not full

		// origin at the top corner
		write_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_node(16'h0000, 16'h0000, 16'h0001, 1'b0);
		queue_node(16'hFFFF, 16'd100, 16'h0002, 1'b0);
		queue_node(16'hFFFE, 16'hFFFE, 16'hFFFF, 1'b0);
		queue_node(16'hFFFE, 16'hFFFE, 16'h8000, 1'b0);

		// origin mid range, one word per quadrant
		write_config(16'h8000, 16'h8000, 16'h5A5A);
		queue_node(16'h8001, 16'h7FFF, 16'h0011, 1'b0);
		queue_node(16'h7FFF, 16'h8001, 16'h0012, 1'b0);
		queue_node(16'h7FFF, 16'h7FFF, 16'h0013, 1'b0);
		queue_node(16'h8001, 16'h8001, 16'h0014, 1'b0);

		// random phases over settings and idle patterns
		for (phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				1: write_config(16'h0000, 16'hFFFF, 16'h0000);
				3: write_config(16'hFFFF, 16'h0000, 16'hFFFF);
				default: write_config(CoordW'($urandom), CoordW'($urandom), IdW'($urandom));
			endcase
			case ((phase / 2) % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 61;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 61;
				end
				default: begin
					send_idle_pct  = 29;
					recv_stall_pct = 29;
				end
			endcase
			add_random_nodes(180);
		end

		wait_idle();
		repeat (8) @(posedge clk);
		$display("Checked %0d result words for %0d candidate words over %0d register settings.",
			results_checked, words_sent, settings_used);
		$display("Status mix: added %0d, replaced %0d, not nearer %0d, on axis %0d, self %0d.",
			status_seen[ST_ADDED], status_seen[ST_REPLACED], status_seen[ST_NOT_NEARER],
			status_seen[ST_AXIS], status_seen[ST_SELF]);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("quadrant_nearest_neighbour_select_core test passed");
		end else begin
			$display("quadrant_nearest_neighbour_select_core test failed");
		end
		$finish;
	end

	// run limit
	initial begin
		#400_000;
		$display("quadrant_nearest_neighbour_select_core test failed");
		$finish;
	end

endmodule
